// ===== src/bmhpq_pkg.sv =====
// Shared types and codes for the binary max-heap priority queue.
package bmhpq_pkg;

    typedef struct packed {
        logic signed [15:0] prio;
        logic        [15:0] tag;
    } entry_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_REJ_FULL   = 2'd1,
        ST_REJ_EMPTY  = 2'd2,
        ST_UNUSED     = 2'd3
    } status_t;

    localparam int unsigned COUNT_W = 7;
    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 48;

endpackage

// ===== src/binary_max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue held in a single synchronous memory.
// One item is taken at a time; s_axis_tready is high only between items. An
// insert or remove walks L levels of the heap in its sift, where L is at
// most log2(CAPACITY): each level needs one memory read, a registered read
// result and a compare with write-back. Rejected commands skip the sift.
// The result register lets the next item be accepted while a result waits
// to be taken.
module binary_max_heap_priority_queue_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // name_tag[15:0], priority_req[31:16]
    input  logic [bmhpq_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // top_tag[15:0], top_priority[31:16], entry_count[38:32],
    // is_empty[39], is_full[40], zero pad[47:41]
    output logic [bmhpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser   // status
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_GET,
        S_DN_CHK,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_GET
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    bmhpq_pkg::entry_t   ent_reg, ent_next;
    bmhpq_pkg::status_t  status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    bmhpq_pkg::status_t  out_status_reg, out_status_next;
    bmhpq_pkg::entry_t   out_top_reg, out_top_next;
    logic [CW-1:0]       out_cnt_reg, out_cnt_next;

    bmhpq_pkg::entry_t   heap_mem [CAPACITY];
    bmhpq_pkg::entry_t   rd_a_reg, rd_b_reg;
    logic [AW-1:0]       ra_a, ra_b, mem_wa;
    logic                mem_we;
    bmhpq_pkg::entry_t   mem_wd;

    logic [CW:0]         kid_w, kid1_w, cnt_w;
    logic [AW-1:0]       parent_idx, pos_m1;
    logic                right_ok, sel_right;
    bmhpq_pkg::entry_t   child;
    logic [AW-1:0]       child_idx;
    logic                in_acc, out_free;
    logic [31:0]         out_cnt_ext;
    bmhpq_pkg::entry_t   in_ent;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_ent   = bmhpq_pkg::entry_t'(s_axis_tdata);

    assign cnt_w      = (CW + 1)'(cnt_reg);
    assign kid_w      = (CW + 1)'({pos_reg, 1'b1});
    assign kid1_w     = kid_w + (CW + 1)'(1);
    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign right_ok   = kid1_w < cnt_w;
    assign sel_right  = right_ok && (rd_a_reg.prio < rd_b_reg.prio);
    assign child      = sel_right ? rd_b_reg : rd_a_reg;
    assign child_idx  = sel_right ? kid1_w[AW-1:0] : kid_w[AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd_a_reg <= heap_mem[ra_a];
        rd_b_reg <= heap_mem[ra_b];
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        ent_next        = ent_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        out_cnt_next    = out_cnt_reg;
        ra_a            = '0;
        ra_b            = '0;
        mem_we          = 1'b0;
        mem_wa          = pos_reg;
        mem_wd          = ent_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    status_next = bmhpq_pkg::ST_DONE;
                    if (s_axis_tuser == bmhpq_pkg::CMD_INSERT) begin
                        if (cnt_reg == CW'(CAPACITY)) begin
                            status_next = bmhpq_pkg::ST_REJ_FULL;
                            state_next  = S_TOP_RD;
                        end else begin
                            ent_next   = in_ent;
                            pos_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_UP_CHK;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = bmhpq_pkg::ST_REJ_EMPTY;
                            state_next  = S_TOP_RD;
                        end else begin
                            cnt_next   = cnt_reg - CW'(1);
                            pos_next   = '0;
                            state_next = (cnt_reg == CW'(1)) ? S_TOP_RD : S_DN_LOAD;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (pos_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = S_TOP_RD;
                end else begin
                    ra_a       = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (rd_a_reg.prio > ent_reg.prio) begin
                    state_next = S_TOP_RD;
                end else begin
                    mem_wd     = rd_a_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_CHK;
                end
            end
            S_DN_LOAD: begin
                ra_a       = cnt_reg[AW-1:0];
                state_next = S_DN_GET;
            end
            S_DN_GET: begin
                ent_next   = rd_a_reg;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (kid_w >= cnt_w) begin
                    mem_we     = 1'b1;
                    state_next = S_TOP_RD;
                end else begin
                    ra_a       = kid_w[AW-1:0];
                    ra_b       = kid1_w[AW-1:0];
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (ent_reg.prio >= child.prio) begin
                    state_next = S_TOP_RD;
                end else begin
                    mem_wd     = child;
                    pos_next   = child_idx;
                    state_next = S_DN_CHK;
                end
            end
            S_TOP_RD: begin
                state_next = S_TOP_GET;
            end
            S_TOP_GET: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_top_next    = (cnt_reg == '0) ? '0 : rd_a_reg;
                    out_cnt_next    = cnt_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        pos_reg        <= pos_next;
        ent_reg        <= ent_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_top_reg    <= out_top_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign out_cnt_ext   = 32'(out_cnt_reg);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'b0,
                            (out_cnt_reg == CW'(CAPACITY)),
                            (out_cnt_reg == '0),
                            out_cnt_ext[bmhpq_pkg::COUNT_W-1:0],
                            out_top_reg};

endmodule

// ===== src/bmhpq_checker.sv =====
// Port-level checker for the heap queue, bound to the top level.
module bmhpq_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[39] |->
            m_axis_tdata[38:32] == 7'd0 && m_axis_tdata[31:0] == 32'd0)
        else $error("empty heap reports a count or top entry");

    a_rej_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == bmhpq_pkg::ST_REJ_FULL |-> m_axis_tdata[40])
        else $error("full rejection while not full");

    a_rej_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == bmhpq_pkg::ST_REJ_EMPTY |-> m_axis_tdata[39])
        else $error("empty rejection while not empty");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser != bmhpq_pkg::ST_UNUSED && m_axis_tdata[47:41] == 7'd0)
        else $error("bad status code or pad bits");

endmodule

bind binary_max_heap_priority_queue_unit bmhpq_checker #(.CAPACITY(CAPACITY)) u_bmhpq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
